// ----- rtl/core/rsp_pkg.sv -----
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared constants, types and GF(256) arithmetic for the Reed-Solomon parity
// encoder (field polynomial 0x11D, primitive element 2).
// ----------------------------------------------------------------------------
`default_nettype none

package rsp_pkg;

  // Largest supported parity length
  localparam int MAX_PARITY = 30;
  // Width of the configuration value
  localparam int CFG_W      = 5;
  // Parity length after reset
  localparam logic [CFG_W-1:0] RESET_PARITY_LENGTH = CFG_W'(7);

  // Length holds 1..MAX_PARITY, an index holds 0..MAX_PARITY-1
  localparam int LEN_W = $clog2(MAX_PARITY + 1);
  localparam int IDX_W = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;

  // Field polynomial; bit 8 is the overflow tap
  localparam logic [8:0] FIELD_POLY = 9'h11D;

  // Remainder queue between the front and the back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [7:0]       byte_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef byte_t [MAX_PARITY-1:0] parity_vec_t;

  // One finished block: remainder (lowest order at index 0) and its length
  typedef struct packed {
    parity_vec_t rem;
    len_t        len;
  } rem_entry_t;

  // Generator builder status seen by the front
  typedef struct packed {
    logic busy;
    len_t len;
  } gen_status_t;

  // GF(256) multiply, shift-and-add over eight bits
  function automatic byte_t gf_mul(byte_t a, byte_t b);
    byte_t acc;
    byte_t x;
    acc = '0;
    x   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY[7:0] : 8'h00);
    end
    return acc;
  endfunction

  // Map a written value onto 1..MAX_PARITY
  function automatic len_t clamp_len(logic [CFG_W-1:0] v);
    len_t n;
    if (v == '0) begin
      n = len_t'(1);
    end else if (int'(v) > MAX_PARITY) begin
      n = len_t'(MAX_PARITY);
    end else begin
      n = len_t'(v);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rsp_in_if.sv -----
// ----------------------------------------------------------------------------
// rsp_in_if
// Data byte channel: valid/ready handshake with one message byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_data;

  modport source (output valid, output data_byte, output last_data, input ready);
  modport sink   (input valid, input data_byte, input last_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rsp_out_if.sv -----
// ----------------------------------------------------------------------------
// rsp_out_if
// Parity byte channel: valid/ready handshake with one parity byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] parity_byte;
  logic       last_parity;

  modport source (output valid, output parity_byte, output last_parity, input ready);
  modport sink   (input valid, input parity_byte, input last_parity, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rsp_gen_build.sv -----
// ----------------------------------------------------------------------------
// rsp_gen_build
// Generator polynomial builder: after reset or a write, multiplies in one
// factor (x + alpha^i) per cycle until the configured parity length is built.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_gen_build (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [rsp_pkg::CFG_W-1:0]  cfg_wr_data,
  output rsp_pkg::gen_status_t            status,
  output rsp_pkg::parity_vec_t            gen_coeffs
);
  import rsp_pkg::*;

  localparam parity_vec_t G_INIT = parity_vec_t'(1);

  logic        busy_r;
  len_t        len_r;
  len_t        step_r;
  byte_t       root_r;
  parity_vec_t g_r;
  parity_vec_t g_nxt;

  // Multiply the running product by (x + root)
  always_comb begin
    g_nxt[0] = gf_mul(g_r[0], root_r);
    for (int m = 1; m < MAX_PARITY; m++) begin
      g_nxt[m] = g_r[m-1] ^ gf_mul(g_r[m], root_r);
    end
  end

  // Restart on reset or write, then advance one root per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      len_r  <= clamp_len(RESET_PARITY_LENGTH);
      step_r <= '0;
      root_r <= 8'h01;
      g_r    <= G_INIT;
    end else if (cfg_wr_en) begin
      busy_r <= 1'b1;
      len_r  <= clamp_len(cfg_wr_data);
      step_r <= '0;
      root_r <= 8'h01;
      g_r    <= G_INIT;
    end else if (busy_r) begin
      g_r    <= g_nxt;
      root_r <= gf_mul(root_r, 8'h02);
      step_r <= step_r + len_t'(1);
      if (step_r == len_r - len_t'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign status.busy = busy_r;
  assign status.len  = len_r;
  assign gen_coeffs  = g_r;

  // Step count never passes the configured length
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r < len_r))
    else $error("generator build step beyond parity length");

endmodule

`default_nettype wire

// ----- rtl/core/rsp_front.sv -----
// ----------------------------------------------------------------------------
// rsp_front
// Front end: runs the parity LFSR one data byte per cycle unless stalled and
// hands the finished remainder of each block to the remainder queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire rsp_pkg::gen_status_t gen_status,
  input  wire rsp_pkg::parity_vec_t gen_coeffs,
  rsp_in_if.sink                    in_ch,
  input  wire logic                 q_full,
  output logic                      push_valid,
  output rsp_pkg::rem_entry_t       push_entry
);
  import rsp_pkg::*;

  // LFSR, lowest-order remainder coefficient at index 0
  parity_vec_t lfsr_r;
  parity_vec_t lfsr_nxt;
  byte_t       coef;
  len_t        len_m1;
  logic        xfer;

  assign len_m1 = gen_status.len - len_t'(1);
  assign coef   = in_ch.data_byte ^ lfsr_r[len_m1[IDX_W-1:0]];

  // Shift toward higher order and add coef times the generator
  always_comb begin
    lfsr_nxt[0] = gf_mul(coef, gen_coeffs[0]);
    for (int m = 1; m < MAX_PARITY; m++) begin
      lfsr_nxt[m] = lfsr_r[m-1] ^ gf_mul(coef, gen_coeffs[m]);
    end
  end

  // Stall while the generator is rebuilt or the queue has no room
  assign in_ch.ready = !gen_status.busy && !q_full;
  assign xfer        = in_ch.valid && in_ch.ready;

  // Hand over the remainder with the last byte of a block
  assign push_valid     = xfer && in_ch.last_data;
  assign push_entry.rem = lfsr_nxt;
  assign push_entry.len = gen_status.len;

  // Advance on each transfer, clear at block end and on a length write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= '0;
    end else if (cfg_wr_en) begin
      lfsr_r <= '0;
    end else if (xfer) begin
      lfsr_r <= in_ch.last_data ? '0 : lfsr_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rsp_queue.sv -----
// ----------------------------------------------------------------------------
// rsp_queue
// Short FIFO of finished remainders between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push_valid,
  input  wire rsp_pkg::rem_entry_t  push_entry,
  output logic                      full,
  output logic                      head_valid,
  output rsp_pkg::rem_entry_t       head_entry,
  input  wire logic                 pop
);
  import rsp_pkg::*;

  rem_entry_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  // Store entries at the write pointer
  always_ff @(posedge clk) begin
    if (push_valid) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push_valid && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (!push_valid && pop) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !full)
    else $error("remainder queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("remainder queue underflow");

endmodule

`default_nettype wire

// ----- rtl/core/rsp_back.sv -----
// ----------------------------------------------------------------------------
// rsp_back
// Back end: takes one remainder from the queue and sends its bytes highest
// order first through a registered output stage, marking the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 head_valid,
  input  wire rsp_pkg::rem_entry_t  head_entry,
  output logic                      pop,
  rsp_out_if.source                 out_ch
);
  import rsp_pkg::*;

  rem_entry_t cur_r;
  logic       active_r;
  idx_t       cnt_r;
  logic       out_valid_r;
  byte_t      out_byte_r;
  logic       out_last_r;
  logic       emit;
  logic       emit_final;
  len_t       head_len_m1;

  // Move one byte into the output stage when it is free or being drained
  assign emit        = active_r && (!out_valid_r || out_ch.ready);
  assign emit_final  = emit && (cnt_r == '0);
  assign pop         = head_valid && (!active_r || emit_final);
  assign head_len_m1 = head_entry.len - len_t'(1);

  // Load the next remainder, count down through its bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (pop) begin
      active_r <= 1'b1;
      cnt_r    <= head_len_m1[IDX_W-1:0];
    end else if (emit) begin
      if (emit_final) begin
        active_r <= 1'b0;
      end
      cnt_r <= cnt_r - idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_entry;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= cur_r.rem[cnt_r];
      out_last_r <= (cnt_r == '0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.parity_byte = out_byte_r;
  assign out_ch.last_parity = out_last_r;

  // Byte counter stays inside the loaded block
  a_cnt_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (len_t'(cnt_r) < cur_r.len))
    else $error("parity byte counter beyond block length");

endmodule

`default_nettype wire

// ----- rtl/core/reed_solomon_parity_encoder.sv -----
// A block's remainder passes the queue, the back-end block register and the output stage.
// Throughput: one data byte per cycle when not stalled; each block sends n parity bytes,
//   one per cycle unless out_ch stalls; input stalls while the generator is rebuilt
//   or two finished blocks already wait. Reset and every parity_length write rebuild it,
//   one factor per cycle, holding in_ch.ready low (length 7 after reset); the LFSR is
//   cleared, reset also empties the queue and the output stage.
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder
// Systematic RS(GF(256), 0x11D) parity encoder with configurable parity length.
// ----------------------------------------------------------------------------
`default_nettype none

module reed_solomon_parity_encoder (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [rsp_pkg::CFG_W-1:0]  cfg_wr_data,
  rsp_in_if.sink                          in_ch,
  rsp_out_if.source                       out_ch
);
  import rsp_pkg::*;

  gen_status_t gen_status;
  parity_vec_t gen_coeffs;
  logic        q_full;
  logic        push_valid;
  rem_entry_t  push_entry;
  logic        head_valid;
  rem_entry_t  head_entry;
  logic        pop;

  // Generator coefficients for the configured length
  rsp_gen_build u_gen (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .status      (gen_status),
    .gen_coeffs  (gen_coeffs)
  );

  // Byte intake and LFSR
  rsp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .gen_status (gen_status),
    .gen_coeffs (gen_coeffs),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  // Finished remainders waiting for output
  rsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  // Parity byte output
  rsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder testbench
// Sends data blocks of random content and length through the encoder under
// several parity lengths, with the clamped ones and mid-block rewrites among
// them. A GF(256) remainder tracker predicts every parity byte, and each
// output transfer is checked in order against it.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_PCT     = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int TARGET_BYTES = 380;
  localparam int SETTLE       = 6;

  typedef struct packed {
    logic [7:0] parity_byte;
    logic       last_parity;
  } parity_item_t;

  // Remainder tracker: own LFSR and generator, plus the parity bytes owed
  class parity_tracker;
    logic [7:0]   lfsr [rsp_pkg::MAX_PARITY];
    logic [7:0]   gen  [rsp_pkg::MAX_PARITY];
    int unsigned  n_parity;
    parity_item_t parity_due [$];
    int unsigned  mismatches;
    int unsigned  parity_checked;
    int unsigned  bytes_taken;
    int unsigned  blocks_closed;
    int unsigned  length_writes;

    function new();
      mismatches     = 0;
      parity_checked = 0;
      bytes_taken    = 0;
      blocks_closed  = 0;
      length_writes  = 0;
      set_length(rsp_pkg::RESET_PARITY_LENGTH);
    endfunction

    function logic [7:0] gf_product(logic [7:0] a, logic [7:0] b);
      logic [8:0] x;
      logic [7:0] acc;
      acc = 8'h00;
      x   = {1'b0, a};
      for (int k = 0; k < 8; k++) begin
        if (b[k]) begin
          acc = acc ^ x[7:0];
        end
        x = x << 1;
        if (x[8]) begin
          x = x ^ rsp_pkg::FIELD_POLY;
        end
      end
      return acc;
    endfunction

    // Clamp the written value, rebuild the generator and clear the LFSR
    function void set_length(logic [rsp_pkg::CFG_W-1:0] v);
      logic [7:0] g [rsp_pkg::MAX_PARITY+1];
      logic [7:0] root;
      int unsigned n;
      n = 32'(v);
      if (n == 0) begin
        n = 1;
      end
      if (n > rsp_pkg::MAX_PARITY) begin
        n = rsp_pkg::MAX_PARITY;
      end
      n_parity = n;
      foreach (g[i]) g[i] = 8'h00;
      g[0] = 8'h01;
      root = 8'h01;
      for (int i = 0; i < n; i++) begin
        for (int j = n; j >= 1; j--) begin
          g[j] = g[j-1] ^ gf_product(g[j], root);
        end
        g[0] = gf_product(g[0], root);
        root = gf_product(root, 8'h02);
      end
      for (int i = 0; i < rsp_pkg::MAX_PARITY; i++) begin
        gen[i]  = (i < n) ? g[i] : 8'h00;
        lfsr[i] = 8'h00;
      end
    endfunction

    // Advance the LFSR by one data byte; close the block on last
    function void absorb_byte(logic [7:0] d, logic last);
      logic [7:0] coef;
      coef = d ^ lfsr[0];
      bytes_taken++;
      for (int j = 0; j + 1 < n_parity; j++) begin
        lfsr[j] = lfsr[j+1] ^ gf_product(coef, gen[n_parity-1-j]);
      end
      lfsr[n_parity-1] = gf_product(coef, gen[0]);
      if (last) begin
        blocks_closed++;
        for (int j = 0; j < n_parity; j++) begin
          parity_due.push_back('{parity_byte: lfsr[j], last_parity: (j + 1 == n_parity)});
        end
        foreach (lfsr[i]) lfsr[i] = 8'h00;
      end
    endfunction

    // Compare one output transfer with the oldest parity byte owed
    function void compare_parity(logic [7:0] b, logic l);
      parity_item_t want;
      parity_checked++;
      if (parity_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected parity byte %02h last=%0b with nothing owed", b, l);
        end
        return;
      end
      want = parity_due.pop_front();
      if (want.parity_byte !== b || want.last_parity !== l) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("parity mismatch: expected %02h last=%0b, got %02h last=%0b",
                   want.parity_byte, want.last_parity, b, l);
        end
      end
    endfunction

    function int pending();
      return parity_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [rsp_pkg::CFG_W-1:0] cfg_wr_data;
  bit   quiet;
  int   stall_cycles;

  rsp_in_if  in_ch ();
  rsp_out_if out_ch ();

  parity_tracker tracker = new();

  reed_solomon_parity_encoder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: stall at random on the falling edge
  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Check every parity transfer
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.compare_parity(out_ch.parity_byte, out_ch.last_parity);
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Send one data byte; called and returns on a falling edge, valid left high
  task automatic send_byte(input logic [7:0] d, input logic last);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = d;
    in_ch.last_data = last;
    do @(posedge clk); while (!in_ch.ready);
    tracker.absorb_byte(d, last);
    @(negedge clk);
  endtask

  task automatic send_block(input int nbytes, input bit finish);
    for (int i = 0; i < nbytes; i++) begin
      send_byte(8'($urandom_range(255)), finish && (i == nbytes - 1));
    end
  endtask

  // Hold the sender until every owed parity byte has come out
  task automatic drain();
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Write the parity length once the encoder has gone idle
  task automatic write_length(input logic [rsp_pkg::CFG_W-1:0] v);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(posedge clk);
    tracker.set_length(v);
    tracker.length_writes++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [rsp_pkg::CFG_W-1:0] pick_length();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return rsp_pkg::CFG_W'(rsp_pkg::MAX_PARITY);
      3:       return rsp_pkg::CFG_W'(1);
      4:       return rsp_pkg::CFG_W'($urandom_range(31));
      default: return rsp_pkg::CFG_W'($urandom_range(2, 8));
    endcase
  endfunction

  initial begin
    int phase;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_data = 1'b0;
    out_ch.ready    = 1'b0;
    quiet           = 1'b0;
    stall_cycles    = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset length, zero and full bytes, mid-block rewrite, clamps
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hA5, 1'b1);
    drain();
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
    write_length('0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    write_length('1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b1);
    write_length(rsp_pkg::CFG_W'(rsp_pkg::MAX_PARITY));
    send_byte(8'hFE, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    write_length(rsp_pkg::CFG_W'(1));
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);

    // Random phases: new length, a few blocks, now and then a torn block
    phase = 0;
    while (tracker.bytes_taken < TARGET_BYTES) begin
      write_length(pick_length());
      quiet = (phase == 3);
      repeat ($urandom_range(2, 6)) begin
        send_block($urandom_range(1, 12), 1'b1);
        if ($urandom_range(9) == 0) begin
          drain();
        end
      end
      if ($urandom_range(3) == 0) begin
        send_block($urandom_range(1, 4), 1'b0);
      end
      quiet = 1'b0;
      phase++;
    end

    // Wait out the last parity bytes and the pipeline
    drain();
    repeat (SETTLE + 4) @(negedge clk);

    $display("covered %0d data bytes in %0d blocks over %0d length writes",
             tracker.bytes_taken, tracker.blocks_closed, tracker.length_writes);
    $display("checked %0d parity bytes, %0d mismatches",
             tracker.parity_checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
